// ===== rtl/core/lpr_pkg.sv =====
package lpr_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_BYTES  = 4;
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = ADDR_BYTES * BYTE_W;
  localparam int LEN_W       = $clog2(ADDR_W + 1);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int INDEX_W     = 6;
  localparam int FIELD_W     = 8;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // For a write beat, mask/port/queue/dscp carry the new entry. For a lookup
  // beat, port/queue/dscp carry the best entry found so far and mask is unused.
  typedef struct packed {
    logic                op;
    logic [INDEX_W-1:0]  entry_index;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   mask;
    logic [FIELD_W-1:0]  port;
    logic [FIELD_W-1:0]  queue;
    logic [FIELD_W-1:0]  dscp;
    logic [LEN_W-1:0]    best_len;
  } beat_t;

  // Matched length of one entry: bytes are walked from the top and the walk
  // stops at the first zero mask byte. Any mismatch in the leading popcount
  // bits of a walked byte makes the whole length zero.
  function automatic logic [LEN_W-1:0] entry_match(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] p,
                                                   input logic [ADDR_W-1:0] m);
    logic [LEN_W-1:0]  total;
    logic              stop;
    logic              fail;
    logic [BYTE_W-1:0] mb;
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] top;
    logic [3:0]        n;
    total = '0;
    stop  = 1'b0;
    fail  = 1'b0;
    for (int j = 0; j < ADDR_BYTES; j++) begin
      mb = m[ADDR_W-1-BYTE_W*j -: BYTE_W];
      x  = (a[ADDR_W-1-BYTE_W*j -: BYTE_W] & mb) ^ p[ADDR_W-1-BYTE_W*j -: BYTE_W];
      n  = 4'd0;
      for (int k = 0; k < BYTE_W; k++) begin
        n = n + 4'(mb[k]);
      end
      top = 8'hFF << (4'd8 - n);
      if (!stop) begin
        if (mb == '0) begin
          stop = 1'b1;
        end else begin
          if ((x & top) != '0) begin
            fail = 1'b1;
          end
          total = total + LEN_W'(n);
        end
      end
    end
    return fail ? '0 : total;
  endfunction

endpackage

// ===== rtl/core/lpr_cell.sv =====
// One table entry. Each beat is registered here while adv is high; a write
// beat whose index matches loads the entry; an active cell compares lookups.
module lpr_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [lpr_pkg::CNT_W-1:0] cell_idx,
  input  logic [lpr_pkg::CNT_W-1:0] cnt,
  input  logic                      in_valid,
  input  lpr_pkg::beat_t            beat_in,
  output logic                      out_valid,
  output lpr_pkg::beat_t            beat_out
);

  logic [lpr_pkg::ADDR_W-1:0]  prefix_r;
  logic [lpr_pkg::ADDR_W-1:0]  mask_r;
  logic [lpr_pkg::FIELD_W-1:0] port_r;
  logic [lpr_pkg::FIELD_W-1:0] queue_r;
  logic [lpr_pkg::FIELD_W-1:0] dscp_r;
  logic                        valid_r;
  lpr_pkg::beat_t              beat_r;
  lpr_pkg::beat_t              beat_nxt;
  logic [lpr_pkg::LEN_W-1:0]   len;
  logic                        hit_w;
  logic                        is_active;
  logic                        is_default;
  logic                        is_lookup;

  assign hit_w      = in_valid && (beat_in.op == lpr_pkg::OP_WRITE) &&
                      (32'(beat_in.entry_index) == 32'(cell_idx));
  assign is_lookup  = in_valid && (beat_in.op == lpr_pkg::OP_LOOKUP);
  assign is_active  = cell_idx < cnt;
  assign is_default = cell_idx == (cnt - 1'b1);
  assign len        = lpr_pkg::entry_match(beat_in.address, prefix_r, mask_r);

  always_comb begin
    beat_nxt = beat_in;
    if (is_lookup && is_active) begin
      if (len > beat_in.best_len) begin
        beat_nxt.best_len = len;
        beat_nxt.port     = port_r;
        beat_nxt.queue    = queue_r;
        beat_nxt.dscp     = dscp_r;
      end
      if (is_default && (beat_nxt.best_len == '0)) begin
        beat_nxt.port  = port_r;
        beat_nxt.queue = queue_r;
        beat_nxt.dscp  = dscp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && hit_w) begin
      prefix_r <= beat_in.address;
      mask_r   <= beat_in.mask;
      port_r   <= beat_in.port;
      queue_r  <= beat_in.queue;
      dscp_r   <= beat_in.dscp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign beat_out  = beat_r;

endmodule

// ===== rtl/core/longest_prefix_route_lookup.sv =====
// Longest-prefix route lookup on a chain of 64 entry cells.
// A lookup result passes through the 64 cell registers and then the output
// register to out_tvalid. Writes return no beat.
// Throughput: one beat per cycle unless held, writes and lookups freely mixed.
// Reset (synchronous, rst_n low): beat valid bits and out_tvalid are cleared,
// entry_count returns to 1; table contents are left as they are.
module longest_prefix_route_lookup (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream. in_tdata from bit 0 up: entry_index[5:0], address[31:0],
  // prefix_mask[31:0], entry_port[7:0], entry_queue[7:0], entry_dscp[7:0],
  // two zero pad bits.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,
  // in_tuser from bit 0 up: opcode.
  input  logic [0:0]  in_tuser,
  // Result stream. out_tdata from bit 0 up: port_index[8:0], queue_index[8:0],
  // dscp_out[7:0], match_length[5:0].
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] REG_ENTRY_COUNT = 3'd0;
  localparam int         DEPTH           = lpr_pkg::TABLE_DEPTH;

  // Configuration. The raw value is kept for read-back; the chain sees the
  // count clamped to the range one to the table depth.
  logic [6:0]                entry_count_r;
  logic [lpr_pkg::CNT_W-1:0] cnt;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == REG_ENTRY_COUNT);
  assign cfg_prdata = (cfg_paddr == REG_ENTRY_COUNT) ? {25'd0, entry_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= 7'd1;
    end else if (cfg_wr) begin
      entry_count_r <= cfg_pwdata[6:0];
    end
  end

  always_comb begin
    if (entry_count_r == 7'd0) begin
      cnt = lpr_pkg::CNT_W'(1);
    end else if (32'(entry_count_r) > DEPTH) begin
      cnt = lpr_pkg::CNT_W'(DEPTH);
    end else begin
      cnt = lpr_pkg::CNT_W'(entry_count_r);
    end
  end

  // The chain. Writes and lookups move down it in order, one cell a cycle, so
  // a lookup sees exactly the writes accepted before it. The whole chain holds
  // only when a finished lookup sits at its end and the output register is
  // still occupied and not being taken.
  logic           chain_valid [DEPTH+1];
  lpr_pkg::beat_t chain_beat  [DEPTH+1];
  logic           adv;
  logic           last_lookup;

  assign chain_valid[0]             = in_tvalid;
  assign chain_beat[0].op           = in_tuser[0];
  assign chain_beat[0].entry_index  = in_tdata[5:0];
  assign chain_beat[0].address      = in_tdata[37:6];
  assign chain_beat[0].mask         = in_tdata[69:38];
  assign chain_beat[0].port         = in_tdata[77:70];
  assign chain_beat[0].queue        = in_tdata[85:78];
  assign chain_beat[0].dscp         = in_tdata[93:86];
  assign chain_beat[0].best_len     = '0;

  assign last_lookup = chain_valid[DEPTH] && (chain_beat[DEPTH].op == lpr_pkg::OP_LOOKUP);
  assign adv         = !(last_lookup && out_tvalid && !out_tready);
  assign in_tready   = adv;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    lpr_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .cell_idx  (lpr_pkg::CNT_W'(k)),
      .cnt       (cnt),
      .in_valid  (chain_valid[k]),
      .beat_in   (chain_beat[k]),
      .out_valid (chain_valid[k+1]),
      .beat_out  (chain_beat[k+1])
    );
  end

  // Output register. Port and queue are stored one-based and leave as
  // zero-based indexes, so a stored zero becomes minus one.
  logic        out_valid_r;
  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && last_lookup) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_lookup) begin
      out_data_r[8:0]   <= {1'b0, chain_beat[DEPTH].port} - 9'd1;
      out_data_r[17:9]  <= {1'b0, chain_beat[DEPTH].queue} - 9'd1;
      out_data_r[25:18] <= chain_beat[DEPTH].dscp;
      out_data_r[31:26] <= 6'(chain_beat[DEPTH].best_len);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // The input side only stalls behind a result that is not being taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

  // A reported length never exceeds the address width.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[31:26]) <= lpr_pkg::ADDR_W))
    else $error("match length out of range");

  // A configuration write lands in the count register.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (entry_count_r == $past(cfg_pwdata[6:0])))
    else $error("entry_count write lost");

  // The clamped count is never zero.
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cnt != '0)
    else $error("clamped entry count is zero");
`endif

endmodule
